### hdl/sphpf_pkg.sv
// Shared types and fixed coefficients for the speech high-pass biquad.
`timescale 1ns / 1ps
package sphpf_pkg;

  typedef logic signed [15:0] sample_t;
  typedef logic signed [31:0] acc_t;

  // Filter history: two past input samples and two past accumulators.
  typedef struct packed {
    sample_t x1;
    sample_t x2;
    acc_t    y1;
    acc_t    y2;
  } sphpf_hist_t;

  localparam sample_t COEF_A1 = 16'sd15614;
  localparam sample_t COEF_A2 = -16'sd7466;
  localparam sample_t COEF_B0 = 16'sd3798;
  localparam sample_t COEF_B1 = -16'sd7596;
  localparam sample_t COEF_B2 = 16'sd3798;
  localparam int unsigned FB_SHIFT = 13;

  localparam acc_t ACC_MAX = 32'sh7FFF_FFFF;
  localparam acc_t ACC_MIN = -32'sh7FFF_FFFF - 32'sd1;

endpackage

### hdl/sphpf_if.sv
// Valid/ready channel interfaces for samples in and filtered samples out.
`timescale 1ns / 1ps
interface sphpf_in_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  sample;
  logic                frame_end;

  modport source (output valid, output sample, output frame_end, input ready);
  modport sink   (input valid, input sample, input frame_end, output ready);
endinterface

interface sphpf_out_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  filtered;
  logic                frame_end_out;

  modport source (output valid, output filtered, output frame_end_out, input ready);
  modport sink   (input valid, input filtered, input frame_end_out, output ready);
endinterface

### hdl/sphpf_datapath.sv
// Combinational biquad arithmetic: accumulator and rounded output for one sample.
`timescale 1ns / 1ps
module sphpf_datapath
  import sphpf_pkg::*;
(
  input  sample_t     x0,
  input  sphpf_hist_t hist,
  output acc_t        acc,
  output sample_t     filtered
);

  // Clamp a 48-bit signed value to the signed 32-bit range.
  function automatic acc_t sat48(input logic signed [47:0] v);
    acc_t res;
    if (v[47:31] != {17{v[47]}}) begin
      res = v[47] ? ACC_MIN : ACC_MAX;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  logic signed [31:0] pb0;
  logic signed [31:0] pb1;
  logic signed [31:0] pb2;
  logic signed [31:0] ff_sum;
  logic signed [47:0] pa1;
  logic signed [47:0] pa2;
  acc_t               fb1;
  acc_t               fb2;
  acc_t               acc_mid;
  acc_t               acc_x4;
  acc_t               rounded;

  // The feedforward terms stay well inside 32 bits, so their doubled sum
  // can never reach the saturation limits.
  assign pb0    = 32'(COEF_B0) * 32'(x0);
  assign pb1    = 32'(COEF_B1) * 32'(hist.x1);
  assign pb2    = 32'(COEF_B2) * 32'(hist.x2);
  assign ff_sum = (pb0 + pb1 + pb2) <<< 1;

  // Arithmetic right shift is a floor division for negative products.
  assign pa1 = 48'(COEF_A1) * 48'(hist.y1);
  assign pa2 = 48'(COEF_A2) * 48'(hist.y2);
  assign fb1 = sat48(pa1 >>> FB_SHIFT);
  assign fb2 = sat48(pa2 >>> FB_SHIFT);

  assign acc_mid = sat48(48'(ff_sum) + 48'(fb1));
  assign acc     = sat48(48'(acc_mid) + 48'(fb2));

  assign acc_x4   = sat48(48'(acc) <<< 2);
  assign rounded  = sat48(48'(acc_x4) + 48'sd32768);
  assign filtered = rounded[31:16];

endmodule

### hdl/speech_preprocess_highpass_biquad_unit.sv
// Top level of the speech pre-processing high-pass biquad filter.
`timescale 1ns / 1ps
// An accepted item moves from the input register into the result register, which drives
// the output channel and holds the result until the output side takes it. One item per
// cycle while the output side is ready; the recursive accumulator path is combinational
// between the input register and the result register, which also updates the history.
// Reset (synchronous, active low) empties both registers and clears the filter history.
module speech_preprocess_highpass_biquad_unit
  import sphpf_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  sphpf_in_if.sink     in_chan,
  sphpf_out_if.source  out_chan
);

  // Input register: holds one accepted sample until the result register can take it.
  logic        s1_valid_r;
  logic        s1_valid_nxt;
  sample_t     s1_sample_r;
  logic        s1_frame_end_r;

  // Result register: drives the output channel directly.
  logic        out_valid_r;
  logic        out_valid_nxt;
  sample_t     out_filtered_r;
  logic        out_frame_end_r;

  // Filter history, advanced only when a sample moves into the result register.
  sphpf_hist_t hist_r;
  sphpf_hist_t hist_nxt;

  acc_t        acc;
  sample_t     filtered;

  logic        in_fire;
  logic        s1_fire;
  logic        out_fire;

  // The input register drains whenever the result register is empty or being read,
  // so a new sample is accepted in the same cycle a finished result is taken.
  assign out_fire      = out_valid_r && out_chan.ready;
  assign s1_fire       = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_fire;
  assign in_fire       = in_chan.valid && in_chan.ready;

  assign s1_valid_nxt  = in_fire || (s1_valid_r && !s1_fire);
  assign out_valid_nxt = s1_fire || (out_valid_r && !out_fire);

  sphpf_datapath u_datapath (
    .x0       (s1_sample_r),
    .hist     (hist_r),
    .acc      (acc),
    .filtered (filtered)
  );

  always_comb begin
    hist_nxt = hist_r;
    if (s1_fire) begin
      hist_nxt.x2 = hist_r.x1;
      hist_nxt.x1 = s1_sample_r;
      hist_nxt.y2 = hist_r.y1;
      hist_nxt.y1 = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      hist_r      <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      hist_r      <= hist_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample_r    <= in_chan.sample;
      s1_frame_end_r <= in_chan.frame_end;
    end
    if (s1_fire) begin
      out_filtered_r  <= filtered;
      out_frame_end_r <= s1_frame_end_r;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.filtered      = out_filtered_r;
  assign out_chan.frame_end_out = out_frame_end_r;

  // A sample leaving the input register always lands in the result register.
  a_fire_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("result register empty after a sample moved forward");

  // The history shifts in exactly the sample that was just filtered.
  a_hist_shift: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> (hist_r.x1 == $past(s1_sample_r)) && (hist_r.x2 == $past(hist_r.x1)))
    else $error("input history did not shift with the filtered sample");

  // The history holds while no sample moves forward.
  a_hist_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> $stable(hist_r))
    else $error("filter history changed without a sample");

  // The frame-end flag travels with its own sample.
  a_flag_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_frame_end_r == $past(s1_frame_end_r))
    else $error("frame-end flag separated from its sample");

endmodule
